// File: hw/rtl/bfr_pkg.sv
// shared types and constants for the batched frame receiver
// no dependencies; imported by bfr_out_buf and batched_frame_receiver_unit
package bfr_pkg;

  // verdict codes carried with each result word
  typedef enum logic [2:0] {
    VerdictAccepted   = 3'd0,
    VerdictRetransmit = 3'd1,
    VerdictBatchAck   = 3'd2,
    VerdictComplete   = 3'd3,
    VerdictAborted    = 3'd4
  } verdict_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgTotalFrames = 2'd0,
    CfgBatchSize   = 2'd1,
    CfgHeaderMode  = 2'd2
  } cfg_index_e;

  // one result word
  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] start_index;
    logic [15:0] payload_length;
    logic [31:0] write_offset;
  } result_t;

  // frame layout
  localparam logic [7:0]  HdrByte0      = 8'h08;
  localparam logic [7:0]  HdrByte1      = 8'hEE;
  localparam logic [7:0]  HdrZero       = 8'h00;
  localparam logic [15:0] HdrLen        = 16'd6;
  localparam logic [15:0] LenLoPos      = 16'd7;
  localparam logic [15:0] LenHiPos      = 16'd8;
  localparam logic [15:0] IdxPos        = 16'd9;
  localparam logic [15:0] FrameOverhead = 16'd14;
  localparam logic [2:0]  ErrLimit      = 3'd3;

  // register reset values
  localparam logic [31:0] TotalFramesRst = 32'd1;
  localparam logic [15:0] BatchSizeRst   = 16'd1;
  localparam logic [7:0]  HeaderModeRst  = 8'h07;

endpackage

// File: hw/rtl/batched_frame_receiver_unit.sv
// batched frame receiver top level: byte-wise frame check and batch sequencing
// depends on bfr_pkg and bfr_out_buf
// a frame_end word's result is registered in the output buffer before it is offered
// throughput: one byte word per cycle while ready; state update is one registered pass
// results queue in an output register plus one skid stage, ready drops only when both hold
// reset: asynchronous active low; registers return to 1/1/7 and all sequencing clears
module batched_frame_receiver_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [31:0] start_index_o,
  output logic [15:0] payload_length_o,
  output logic [31:0] write_offset_o
);
  import bfr_pkg::*;

  localparam logic [15:0] MaxBytes = 16'(MAX_FRAME_BYTES);

  // configuration registers
  logic [31:0] total_frames_q;
  logic [15:0] batch_size_q;
  logic [7:0]  header_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_frames_q <= TotalFramesRst;
      batch_size_q   <= BatchSizeRst;
      header_mode_q  <= HeaderModeRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTotalFrames: total_frames_q <= cfg_wdata_i;
        CfgBatchSize:   batch_size_q   <= cfg_wdata_i[15:0];
        CfgHeaderMode:  header_mode_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencing state
  logic [15:0] pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic        hdr_good_q, hdr_good_d;
  logic        chk_good_q, chk_good_d;
  logic [15:0] flen_q, flen_d;
  logic [31:0] fidx_q, fidx_d;
  logic [31:0] bstart_q, bstart_d;
  logic [15:0] boff_q, boff_d;
  logic [2:0]  err_q, err_d;
  logic [31:0] img_q, img_d;
  logic        finished_q, finished_d;

  logic        in_fire, buf_full, res_push;
  result_t     res_d, res_out;
  logic [7:0]  want;
  logic [16:0] pos_inc;
  logic [15:0] bsize;
  logic [31:0] expect_idx;
  logic        frame_ok;
  logic [15:0] pay;

  assign in_ready_o = !buf_full;
  assign in_fire    = in_valid_i && in_ready_o;
  assign pos_inc    = {1'b0, pos_q} + 17'd1;
  assign bsize      = (batch_size_q == 16'd0) ? 16'd1 : batch_size_q;
  assign expect_idx = bstart_q + {16'd0, boff_q};

  // expected header byte at the current position
  always_comb begin
    case (pos_q[2:0])
      3'd0:    want = HdrByte0;
      3'd1:    want = HdrByte1;
      3'd5:    want = header_mode_q;
      default: want = HdrZero;
    endcase
  end

  // per-word state update and verdict
  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    hdr_good_d = hdr_good_q;
    chk_good_d = chk_good_q;
    flen_d     = flen_q;
    fidx_d     = fidx_q;
    bstart_d   = bstart_q;
    boff_d     = boff_q;
    err_d      = err_q;
    img_d      = img_q;
    finished_d = finished_q;
    res_push   = 1'b0;
    res_d      = '0;
    frame_ok   = 1'b0;
    pay        = '0;
    if (in_fire) begin
      if (req_type_i) begin
        // new transfer clears everything but the registers
        pos_d      = '0;
        sum_d      = '0;
        hdr_good_d = 1'b1;
        chk_good_d = 1'b0;
        flen_d     = '0;
        fidx_d     = '0;
        bstart_d   = '0;
        boff_d     = '0;
        err_d      = '0;
        img_d      = '0;
        finished_d = 1'b0;
      end else if (finished_q) begin
        if (frame_end_i) begin
          pos_d      = '0;
          sum_d      = '0;
          hdr_good_d = 1'b1;
          chk_good_d = 1'b0;
          flen_d     = '0;
          fidx_d     = '0;
        end
      end else begin
        // take the byte unless past the buffer limit
        if (pos_q < MaxBytes) begin
          if (pos_q < HdrLen && data_byte_i != want) begin
            hdr_good_d = 1'b0;
          end
          if (pos_q == LenLoPos) begin
            flen_d[7:0] = data_byte_i;
          end
          if (pos_q == LenHiPos) begin
            flen_d[15:8] = data_byte_i;
          end
          case (pos_q)
            16'd9:   fidx_d[7:0]   = fidx_q[7:0]   | data_byte_i;
            16'd10:  fidx_d[15:8]  = fidx_q[15:8]  | data_byte_i;
            16'd11:  fidx_d[23:16] = fidx_q[23:16] | data_byte_i;
            16'd12:  fidx_d[31:24] = fidx_q[31:24] | data_byte_i;
            default: ;
          endcase
          if (pos_q < IdxPos) begin
            sum_d = sum_q + data_byte_i;
          end else if (pos_inc == {1'b0, flen_q}) begin
            if (flen_q >= FrameOverhead && sum_q == data_byte_i) begin
              chk_good_d = 1'b1;
            end
          end else if (pos_inc < {1'b0, flen_q}) begin
            sum_d = sum_q + data_byte_i;
          end
          pos_d = pos_inc[15:0];
        end
        // close the frame slot
        if (frame_end_i) begin
          res_push = 1'b1;
          frame_ok = hdr_good_d && chk_good_d && (fidx_d == expect_idx);
          if (!frame_ok) begin
            if (err_q > ErrLimit) begin
              err_d         = '0;
              finished_d    = 1'b1;
              res_d.verdict = VerdictAborted;
            end else begin
              err_d             = err_q + 3'd1;
              boff_d            = '0;
              res_d.start_index = bstart_q;
              res_d.verdict     = VerdictRetransmit;
            end
          end else begin
            err_d                = '0;
            pay                  = flen_d - FrameOverhead;
            res_d.payload_length = pay;
            res_d.write_offset   = img_q;
            img_d                = img_q + {16'd0, pay};
            if (fidx_d == total_frames_q - 32'd1) begin
              finished_d    = 1'b1;
              res_d.verdict = VerdictComplete;
            end else if (boff_q == bsize - 16'd1) begin
              boff_d            = '0;
              bstart_d          = bstart_q + {16'd0, bsize};
              res_d.start_index = bstart_q + {16'd0, bsize};
              res_d.verdict     = VerdictBatchAck;
            end else begin
              boff_d        = boff_q + 16'd1;
              res_d.verdict = VerdictAccepted;
            end
          end
          pos_d      = '0;
          sum_d      = '0;
          hdr_good_d = 1'b1;
          chk_good_d = 1'b0;
          flen_d     = '0;
          fidx_d     = '0;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      hdr_good_q <= 1'b1;
      chk_good_q <= 1'b0;
      flen_q     <= '0;
      fidx_q     <= '0;
      bstart_q   <= '0;
      boff_q     <= '0;
      err_q      <= '0;
      img_q      <= '0;
      finished_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      hdr_good_q <= hdr_good_d;
      chk_good_q <= chk_good_d;
      flen_q     <= flen_d;
      fidx_q     <= fidx_d;
      bstart_q   <= bstart_d;
      boff_q     <= boff_d;
      err_q      <= err_d;
      img_q      <= img_d;
      finished_q <= finished_d;
    end
  end

  // result register and skid stage
  bfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .item_i      (res_d),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .item_o      (res_out)
  );

  assign verdict_o        = res_out.verdict;
  assign start_index_o    = res_out.start_index;
  assign payload_length_o = res_out.payload_length;
  assign write_offset_o   = res_out.write_offset;

  // a result only ever comes from an accepted frame end word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      res_push |-> (in_fire && frame_end_i && !req_type_i))
    else $error("result without frame end");
  // a finished transfer gives nothing until restarted
  assert property (@(posedge clk_i) disable iff (!rst_ni) finished_q |-> !res_push)
    else $error("result after finish");
  // the bad frame run never goes past the abort point
  assert property (@(posedge clk_i) disable iff (!rst_ni) err_q <= 3'd4)
    else $error("error count out of range");

endmodule

// File: hw/rtl/bfr_out_buf.sv
// result output register with a skid stage behind it
// depends on bfr_pkg for the result word type
module bfr_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bfr_pkg::result_t item_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bfr_pkg::result_t item_o
);
  import bfr_pkg::*;

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    pop;

  assign pop         = main_valid_q && out_ready_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign item_o      = main_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (push_i) begin
        main_q <= item_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_q <= item_i;
      end else begin
        main_q <= item_i;
      end
    end
  end

  // skid only fills behind a held word
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> main_valid_q)
    else $error("skid word without output word");
  // no push while the skid stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !skid_valid_q)
    else $error("push into full buffer");
  // a held word behind a stall moves into the output on the next take
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (skid_valid_q && out_ready_i) |=> (main_valid_q && main_q == $past(skid_q)))
    else $error("skid word lost");

endmodule
